>>> src/assert_macros.svh
// shared assertion macros for the chunked body decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every edge outside reset
`define HCBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication checked outside reset
`define HCBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/hcbd_pkg.sv
package hcbd_pkg;

    // body status codes
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_BIG  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;

    // framing characters
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // chunk size accumulator width
    localparam int CHUNK_W = 64;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_item;

endpackage

>>> src/http_chunked_body_decoder_unit.sv
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------------
// input    | i_in_valid / o_in_ready    | i_data_byte
// output   | o_out_valid / i_out_ready  | o_payload_valid, o_payload_byte, o_body_status
// config   | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// one byte per cycle sustained while the output side takes results; each byte enters the
//   queue, then a sequencer step loads its result into the output register, from which it leaves
// the sequencer step is the 64-bit size shift or decrement and the byte-count compare
// synchronous active-low reset; registers return to their reset values, queue empties
// input and output stall apart: the queue absorbs up to two bytes while the result waits
module http_chunked_body_decoder_unit #(
    parameter int MAX_SIZE_CHARS = 20,
    parameter int COUNT_WIDTH    = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // byte stream in
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_data_byte,
    // decoded results out
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_payload_valid,
    output logic [7:0]             o_payload_byte,
    output logic [1:0]             o_body_status,
    // register writes
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [COUNT_WIDTH-1:0] i_cfg_data
);
    import hcbd_pkg::*;

    // default size limit of one mebibyte
    localparam logic [COUNT_WIDTH-1:0] MAX_RESET = COUNT_WIDTH'(1048576);

    logic                   r_transfer_mode;
    logic [COUNT_WIDTH-1:0] r_content_length;
    logic [COUNT_WIDTH-1:0] r_max_body_size;

    logic  push;
    logic  q_ready;
    logic  q_valid;
    logic  q_pop;
    t_item front_item;
    t_item back_item;
    logic  len_load;

    // a content length write also reloads the remaining length
    assign len_load = i_cfg_we && (i_cfg_idx == REG_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transfer_mode  <= 1'b0;
            r_content_length <= '0;
            r_max_body_size  <= MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:   r_transfer_mode  <= i_cfg_data[0];
                REG_LENGTH: r_content_length <= i_cfg_data;
                REG_MAX:    r_max_body_size  <= i_cfg_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // front: classify each byte (cr, lf, hex digit value)
    hcbd_front u_front (
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .o_in_ready  (o_in_ready),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_item      (front_item)
    );

    // short queue decoupling the two sides
    hcbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (back_item)
    );

    // back: framing sequencer, counters and the result register
    hcbd_back #(
        .MAX_SIZE_CHARS (MAX_SIZE_CHARS),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (r_transfer_mode),
        .i_content_length (r_content_length),
        .i_max_body_size  (r_max_body_size),
        .i_len_load       (len_load),
        .i_len_value      (i_cfg_data),
        .i_q_valid        (q_valid),
        .i_item           (back_item),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_payload_valid  (o_payload_valid),
        .o_payload_byte   (o_payload_byte),
        .o_body_status    (o_body_status)
    );

endmodule

>>> src/hcbd_front.sv
module hcbd_front (
    input  logic           i_in_valid,
    input  logic [7:0]     i_data_byte,
    output logic           o_in_ready,
    input  logic           i_q_ready,
    output logic           o_push,
    output hcbd_pkg::t_item o_item
);
    import hcbd_pkg::*;

    logic is_digit;
    logic is_lower;
    logic is_upper;

    // hex digit ranges
    assign is_digit = (i_data_byte >= 8'h30) && (i_data_byte <= 8'h39);
    assign is_lower = (i_data_byte >= 8'h61) && (i_data_byte <= 8'h66);
    assign is_upper = (i_data_byte >= 8'h41) && (i_data_byte <= 8'h46);

    always_comb begin
        o_item.data    = i_data_byte;
        o_item.is_cr   = (i_data_byte == CHAR_CR);
        o_item.is_lf   = (i_data_byte == CHAR_LF);
        o_item.is_hex  = is_digit || is_lower || is_upper;
        // letters sit at low nibble 1..6, so add 9 to reach 10..15
        o_item.hex_val = is_digit ? i_data_byte[3:0] : (i_data_byte[3:0] + 4'd9);
    end

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid && i_q_ready;

endmodule

>>> src/hcbd_queue.sv
module hcbd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hcbd_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_pop,
    output hcbd_pkg::t_item o_item
);
    import hcbd_pkg::*;

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop && o_valid) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

`include "assert_macros.svh"

    `HCBD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= 2'd2, "queue count beyond depth")
    `HCBD_ASSERT(a_ptr_track, i_clk, i_rst_n, ((r_count == 2'd1) == (r_wptr != r_rptr)), "queue pointers disagree with count")

endmodule

>>> src/hcbd_back.sv
module hcbd_back #(
    parameter int MAX_SIZE_CHARS = 20,
    parameter int COUNT_WIDTH    = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_mode,
    input  logic [COUNT_WIDTH-1:0] i_content_length,
    input  logic [COUNT_WIDTH-1:0] i_max_body_size,
    input  logic                   i_len_load,
    input  logic [COUNT_WIDTH-1:0] i_len_value,
    input  logic                   i_q_valid,
    input  hcbd_pkg::t_item        i_item,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_payload_valid,
    output logic [7:0]             o_payload_byte,
    output logic [1:0]             o_body_status
);
    import hcbd_pkg::*;

    localparam int SCW = $clog2(MAX_SIZE_CHARS + 1);

    localparam logic [2:0] PH_SIZE = 3'd0;
    localparam logic [2:0] PH_LF1  = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_CR2  = 3'd3;
    localparam logic [2:0] PH_LF2  = 3'd4;

    logic [2:0]             r_phase,      n_phase;
    logic [SCW-1:0]         r_cnt,        n_cnt;
    logic [CHUNK_W-1:0]     r_chunk_left, n_chunk_left;
    logic                   r_has_digit,  n_has_digit;
    logic                   r_stopped,    n_stopped;
    logic                   r_ovf,        n_ovf;
    logic                   r_final,      n_final;
    logic [COUNT_WIDTH:0]   r_bytes,      n_bytes;
    logic [COUNT_WIDTH-1:0] r_len_left,   n_len_left;
    logic [1:0]             r_status,     n_status;
    logic                   n_pv;

    logic                   r_out_vld;
    logic                   r_o_pv;
    logic [7:0]             r_o_pb;
    logic [1:0]             r_o_st;

    assign o_q_pop         = i_q_valid && (!r_out_vld || i_out_ready);
    assign o_out_valid     = r_out_vld;
    assign o_payload_valid = r_o_pv;
    assign o_payload_byte  = r_o_pb;
    assign o_body_status   = r_o_st;

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_chunk_left = r_chunk_left;
        n_has_digit  = r_has_digit;
        n_stopped    = r_stopped;
        n_ovf        = r_ovf;
        n_final      = r_final;
        n_bytes      = r_bytes;
        n_len_left   = r_len_left;
        n_status     = r_status;
        n_pv         = 1'b0;

        if (o_q_pop && (r_status == ST_BUSY)) begin
            if (!i_mode) begin
                if (r_bytes != '1) begin
                    n_bytes = r_bytes + 1'b1;
                end
                // count after this byte exceeds the limit
                if (r_bytes >= {1'b0, i_max_body_size}) begin
                    n_status = ST_BIG;
                end else begin
                    case (r_phase)
                        PH_SIZE: begin
                            if (i_item.is_cr) begin
                                if (!r_has_digit || r_ovf) begin
                                    n_status = ST_BAD;
                                end else begin
                                    n_final     = (r_chunk_left == '0);
                                    n_cnt       = '0;
                                    n_has_digit = 1'b0;
                                    n_stopped   = 1'b0;
                                    n_ovf       = 1'b0;
                                    n_phase     = PH_LF1;
                                end
                            end else begin
                                if (!r_stopped) begin
                                    if (!i_item.is_hex) begin
                                        n_stopped = 1'b1;
                                    end else if (r_chunk_left[CHUNK_W-1 -: 4] != 4'd0) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        n_chunk_left = {r_chunk_left[CHUNK_W-5:0],
                                                        i_item.hex_val};
                                        n_has_digit  = 1'b1;
                                    end
                                end
                                n_cnt = r_cnt + 1'b1;
                                if (n_cnt >= SCW'(MAX_SIZE_CHARS)) begin
                                    n_status = ST_BAD;
                                end
                            end
                        end
                        PH_LF1: begin
                            if (!i_item.is_lf) begin
                                n_status = ST_BAD;
                            end else begin
                                n_phase = (r_chunk_left == '0) ? PH_CR2 : PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            n_pv = 1'b1;
                            if (r_chunk_left != '0) begin
                                n_chunk_left = r_chunk_left - 1'b1;
                            end
                            if (r_chunk_left <= CHUNK_W'(1)) begin
                                n_phase = PH_CR2;
                            end
                        end
                        PH_CR2: begin
                            if (!i_item.is_cr) begin
                                n_status = ST_BAD;
                            end else begin
                                n_phase = PH_LF2;
                            end
                        end
                        PH_LF2: begin
                            if (!i_item.is_lf) begin
                                n_status = ST_BAD;
                            end else if (r_final) begin
                                n_status = ST_DONE;
                            end else begin
                                n_chunk_left = '0;
                                n_phase      = PH_SIZE;
                            end
                        end
                        default: begin
                            n_status = ST_BAD;
                        end
                    endcase
                end
            end else begin
                if (i_content_length > i_max_body_size) begin
                    n_status = ST_BIG;
                end else if (r_len_left == '0) begin
                    n_status = ST_DONE;
                end else begin
                    n_pv       = 1'b1;
                    n_len_left = r_len_left - 1'b1;
                    if (r_len_left == COUNT_WIDTH'(1)) begin
                        n_status = ST_DONE;
                    end
                end
            end
        end

        if (i_len_load) begin
            n_len_left = i_len_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_cnt        <= '0;
            r_chunk_left <= '0;
            r_has_digit  <= 1'b0;
            r_stopped    <= 1'b0;
            r_ovf        <= 1'b0;
            r_final      <= 1'b0;
            r_bytes      <= '0;
            r_len_left   <= '0;
            r_status     <= ST_BUSY;
            r_out_vld    <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_chunk_left <= n_chunk_left;
            r_has_digit  <= n_has_digit;
            r_stopped    <= n_stopped;
            r_ovf        <= n_ovf;
            r_final      <= n_final;
            r_bytes      <= n_bytes;
            r_len_left   <= n_len_left;
            r_status     <= n_status;
            if (o_q_pop) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result fields, loaded with each step
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_o_pv <= n_pv;
            r_o_pb <= n_pv ? i_item.data : 8'd0;
            r_o_st <= n_status;
        end
    end

`include "assert_macros.svh"

    `HCBD_ASSERT_NEXT(a_status_sticky, i_clk, i_rst_n, r_status != ST_BUSY, r_status == $past(r_status), "final body status changed")
    `HCBD_ASSERT(a_data_status, i_clk, i_rst_n, !(r_out_vld && r_o_pv) || (r_o_st == ST_BUSY) || (r_o_st == ST_DONE), "payload byte carried with an error status")
    `HCBD_ASSERT(a_data_zero, i_clk, i_rst_n, !(r_out_vld && !r_o_pv) || (r_o_pb == 8'd0), "non-payload result carries a byte")

endmodule

>>> test/http_chunked_body_decoder_unit_tb.sv
`timescale 1ns / 100ps

module http_chunked_body_decoder_unit_tb;
    import hcbd_pkg::*;

    localparam int     COUNT_W         = 40;
    localparam int     SIZE_LINE_LIMIT = 20;
    localparam int     RANDOM_BYTES    = 520;
    localparam int     RX_HOLD_CYCLES  = 60;
    localparam int     SETTLE_CYCLES   = 8;
    localparam longint CYCLE_LIMIT     = 1000000;

    localparam logic MODE_CHUNKED = 1'b0;
    localparam logic MODE_LENGTH  = 1'b1;

    localparam logic [COUNT_W-1:0] DEFAULT_MAX_BODY = 40'd1048576;
    localparam logic [COUNT_W-1:0] COUNT_ALL_ONES   = '1;

    // where the chunk parser stands within the framing
    typedef enum logic [2:0] {
        SIZE_LINE,
        SIZE_LF,
        CHUNK_DATA,
        DATA_CR,
        DATA_LF
    } t_frame;

    // ways the single body of the run is brought to its end
    typedef enum logic [3:0] {
        END_ZERO_CHUNK,
        END_LENGTH_DONE,
        END_NO_DIGIT,
        END_SIZE_OVERFLOW,
        END_SIZE_TOO_LONG,
        END_BAD_SIZE_LF,
        END_BAD_DATA_CR,
        END_BAD_DATA_LF,
        END_CHUNKED_TOO_BIG,
        END_LENGTH_TOO_BIG
    } t_ending;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [1:0] body_status;
    } t_decoded;

    // dut signals; the inputs are all known from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_data_byte = 8'h00;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_payload_valid;
    logic [7:0]         o_payload_byte;
    logic [1:0]         o_body_status;
    logic               i_cfg_we    = 1'b0;
    logic [1:0]         i_cfg_idx   = REG_MODE;
    logic [COUNT_W-1:0] i_cfg_data  = '0;

    // register copies held by the decoder model
    logic               cfg_mode = MODE_CHUNKED;
    logic [COUNT_W-1:0] cfg_len  = '0;
    logic [COUNT_W-1:0] cfg_max  = DEFAULT_MAX_BODY;

    // decoder model state
    t_frame             frame           = SIZE_LINE;
    logic [4:0]         size_len        = '0;
    logic [63:0]        chunk_rem       = '0;
    logic               size_seen_digit = 1'b0;
    logic               size_ext        = 1'b0;
    logic               size_ovf        = 1'b0;
    logic               last_chunk      = 1'b0;
    logic [COUNT_W:0]   body_count      = '0;
    logic [COUNT_W-1:0] len_rem         = '0;
    logic [1:0]         body_st         = ST_BUSY;

    // decoded results still owed by the block, oldest first
    t_decoded decoded_q[$];

    // run bookkeeping
    bit          gaps_on      = 1'b0;
    bit          rx_hold_req  = 1'b0;
    int unsigned bytes_sent   = 0;
    int unsigned payload_seen = 0;
    int unsigned detour_count = 0;
    int unsigned limit_writes = 0;
    int unsigned error_count  = 0;
    longint      cycle_count  = 0;
    t_ending     body_ending  = END_ZERO_CHUNK;

    http_chunked_body_decoder_unit #(
        .MAX_SIZE_CHARS (SIZE_LINE_LIMIT),
        .COUNT_WIDTH    (COUNT_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_body_status   (o_body_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // mostly no gap, now and then a short gap, rarely a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // {is hex digit, digit value}
    function automatic logic [4:0] hex_digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'd0;
    endfunction

    // advances the decoder model by one body byte and gives the result it must produce
    function automatic t_decoded decode_body_byte(input logic [7:0] c);
        t_decoded   res;
        logic [4:0] hx;
        res = '0;
        if (body_st == ST_BUSY) begin
            if (cfg_mode == MODE_CHUNKED) begin
                // framing bytes count towards the limit too, saturating
                if (body_count != '1) body_count = body_count + 1'b1;
                if (body_count > {1'b0, cfg_max}) begin
                    body_st = ST_BIG;
                end else begin
                    case (frame)
                        SIZE_LINE: begin
                            if (c == CHAR_CR) begin
                                if (!size_seen_digit || size_ovf) begin
                                    body_st = ST_BAD;
                                end else begin
                                    last_chunk      = (chunk_rem == 64'd0);
                                    size_len        = '0;
                                    size_seen_digit = 1'b0;
                                    size_ext        = 1'b0;
                                    size_ovf        = 1'b0;
                                    frame           = SIZE_LF;
                                end
                            end else begin
                                // digits stop at the first non-hex character
                                if (!size_ext) begin
                                    hx = hex_digit_of(c);
                                    if (!hx[4]) begin
                                        size_ext = 1'b1;
                                    end else if (chunk_rem[63:60] != 4'd0) begin
                                        size_ovf = 1'b1;
                                    end else begin
                                        chunk_rem       = {chunk_rem[59:0], hx[3:0]};
                                        size_seen_digit = 1'b1;
                                    end
                                end
                                size_len = size_len + 1'b1;
                                if (size_len >= SIZE_LINE_LIMIT) body_st = ST_BAD;
                            end
                        end
                        SIZE_LF: begin
                            if (c != CHAR_LF) body_st = ST_BAD;
                            else frame = (chunk_rem == 64'd0) ? DATA_CR : CHUNK_DATA;
                        end
                        CHUNK_DATA: begin
                            res.payload_valid = 1'b1;
                            res.payload_byte  = c;
                            if (chunk_rem != 64'd0) chunk_rem = chunk_rem - 1'b1;
                            if (chunk_rem == 64'd0) frame = DATA_CR;
                        end
                        DATA_CR: begin
                            if (c != CHAR_CR) body_st = ST_BAD;
                            else frame = DATA_LF;
                        end
                        DATA_LF: begin
                            if (c != CHAR_LF) begin
                                body_st = ST_BAD;
                            end else if (last_chunk) begin
                                body_st = ST_DONE;
                            end else begin
                                chunk_rem = '0;
                                frame     = SIZE_LINE;
                            end
                        end
                        default: body_st = ST_BAD;
                    endcase
                end
            end else begin
                // fixed length body
                if (cfg_len > cfg_max) begin
                    body_st = ST_BIG;
                end else if (len_rem == '0) begin
                    body_st = ST_DONE;
                end else begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = c;
                    len_rem = len_rem - 1'b1;
                    if (len_rem == '0) body_st = ST_DONE;
                end
            end
        end
        res.body_status = body_st;
        return res;
    endfunction

    // result side: random stalls, plus one long hold-off when asked for
    initial begin : result_ready
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                stall_left  = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (gaps_on) stall_left = pick_gap();
            end
        end
    end

    // every result transfer is compared with the oldest owed result
    always @(posedge i_clk) begin : check_results
        t_decoded want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (o_payload_valid === 1'b1) payload_seen++;
            if (decoded_q.size() == 0) begin
                $error("result transfer with no byte outstanding");
                error_count++;
            end else begin
                want = decoded_q.pop_front();
                if (o_payload_valid !== want.payload_valid) begin
                    $error("payload_valid: expected %0d, actual %0d",
                           want.payload_valid, o_payload_valid);
                    error_count++;
                end
                if (o_payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0h, actual %0h",
                           want.payload_byte, o_payload_byte);
                    error_count++;
                end
                if (o_body_status !== want.body_status) begin
                    $error("body_status: expected %0d, actual %0d",
                           want.body_status, o_body_status);
                    error_count++;
                end
            end
        end
    end

    // one byte transfer; the model is stepped at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decoded_q.push_back(decode_body_byte(b));
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    // input goes quiet until every owed result has come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    // register write, only ever issued with the block idle
    task automatic write_reg(input logic [1:0] idx, input logic [COUNT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE: cfg_mode = value[0];
            REG_LENGTH: begin
                cfg_len = value;
                len_rem = value;
            end
            REG_MAX: cfg_max = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // short excursion into length mode; the length always stays ahead so the body goes on
    task automatic length_detour(input int unsigned n);
        wait_results_drained();
        write_reg(REG_MODE, COUNT_W'(MODE_LENGTH));
        write_reg(REG_LENGTH, COUNT_W'(n + $urandom_range(1, 20)));
        repeat (n) send_byte(8'($urandom));
        wait_results_drained();
        write_reg(REG_MODE, COUNT_W'(MODE_CHUNKED));
        detour_count++;
    endtask

    // well formed chunk with random size, digit case, leading zeros and extension
    task automatic send_random_chunk();
        logic [7:0]  seq[$];
        logic [7:0]  c;
        logic [4:0]  hx;
        logic [3:0]  nib;
        int unsigned size;
        int unsigned digits;
        int unsigned room;
        int unsigned ext_len;
        size   = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
        digits = (size > 15) ? 2 : 1;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, SIZE_LINE_LIMIT - 1 - digits)) seq.push_back("0");
        end
        for (int i = digits - 1; i >= 0; i--) begin
            nib = 4'(size >> (4 * i));
            if (nib < 4'd10) c = 8'h30 + nib;
            else if ($urandom_range(0, 1) != 0) c = 8'h41 + nib - 8'd10;
            else c = 8'h61 + nib - 8'd10;
            seq.push_back(c);
        end
        // extension: opens on a non-hex character, then anything but CR
        room = SIZE_LINE_LIMIT - 1 - seq.size();
        if (room != 0 && $urandom_range(0, 2) == 0) begin
            ext_len = $urandom_range(1, room);
            do begin
                c  = 8'($urandom);
                hx = hex_digit_of(c);
            end while (hx[4] || c == CHAR_CR);
            seq.push_back(c);
            repeat (ext_len - 1) begin
                do c = 8'($urandom); while (c == CHAR_CR);
                seq.push_back(c);
            end
        end
        seq.push_back(CHAR_CR);
        seq.push_back(CHAR_LF);
        repeat (size) seq.push_back(8'($urandom));
        seq.push_back(CHAR_CR);
        seq.push_back(CHAR_LF);
        // now and then the mode flips at whatever point of the framing we are in
        foreach (seq[i]) begin
            if ($urandom_range(0, 59) == 0) length_detour($urandom_range(1, 12));
            send_byte(seq[i]);
        end
    endtask

    // reset config: a lone 0xff byte, then 0x00 and a framing CR as payload,
    // leading zeros, an extension and a size line one short of the limit
    task automatic test_directed_chunks();
        gaps_on = 1'b0;
        send_text("1");
        send_crlf();
        send_byte(8'hFF);
        send_crlf();
        send_text("0000000000002;AbcDe");
        send_crlf();
        send_byte(8'h00);
        send_byte(CHAR_CR);
        send_crlf();
    endtask

    // length mode at the widest settings, then length equal to the limit
    task automatic test_length_extremes();
        wait_results_drained();
        write_reg(REG_MAX, COUNT_ALL_ONES);
        write_reg(REG_MODE, COUNT_W'(MODE_LENGTH));
        write_reg(REG_LENGTH, COUNT_ALL_ONES);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_results_drained();
        write_reg(REG_LENGTH, 40'd3);
        write_reg(REG_MAX, 40'd3);
        send_byte(8'h5A);
        send_byte(8'hA5);
        wait_results_drained();
        write_reg(REG_MAX, DEFAULT_MAX_BODY);
        write_reg(REG_MODE, COUNT_W'(MODE_CHUNKED));
    endtask

    // the chunk parser keeps its place across a spell in length mode
    task automatic test_mode_switch_mid_chunk();
        gaps_on = 1'b1;
        send_text("8");
        send_crlf();
        repeat (3) send_byte(8'($urandom));
        length_detour(4);
        repeat (5) send_byte(8'($urandom));
        send_crlf();
    endtask

    // byte count lands exactly on the limit without going over
    task automatic test_count_at_limit();
        wait_results_drained();
        write_reg(REG_MAX, 40'(body_count) + 40'd8);
        send_text("3");
        send_crlf();
        repeat (3) send_byte(8'($urandom));
        send_crlf();
        wait_results_drained();
        write_reg(REG_MAX, COUNT_ALL_ONES);
        limit_writes++;
    endtask

    // result side holds off while bytes keep coming, so the input has to stall
    task automatic test_output_hold_off();
        gaps_on     = 1'b0;
        rx_hold_req = 1'b1;
        send_text("18");
        send_crlf();
        repeat (24) send_byte(8'($urandom));
        send_crlf();
    endtask

    // input pauses mid chunk until nothing is owed
    task automatic test_input_pause();
        gaps_on = 1'b1;
        send_text("6");
        send_crlf();
        repeat (3) send_byte(8'($urandom));
        wait_results_drained();
        repeat (3) send_byte(8'($urandom));
        send_crlf();
    endtask

    task automatic test_random_chunks();
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 11) == 0) begin
                wait_results_drained();
                case ($urandom_range(0, 2))
                    0: write_reg(REG_MAX, DEFAULT_MAX_BODY);
                    1: write_reg(REG_MAX, COUNT_ALL_ONES);
                    default: write_reg(REG_MAX, {8'($urandom_range(1, 255)), 32'($urandom)});
                endcase
                limit_writes++;
            end
            send_random_chunk();
        end
    endtask

    // one way of finishing the body, then bytes that must see the status stick
    task automatic test_body_end();
        logic [COUNT_W-1:0] limit;
        int unsigned        n;
        gaps_on     = 1'b1;
        body_ending = t_ending'($urandom_range(0, 9));
        case (body_ending)
            END_ZERO_CHUNK: begin
                if ($urandom_range(0, 1) != 0) send_text("0");
                else send_text("000;last");
                send_crlf();
                send_crlf();
            end
            END_LENGTH_DONE: begin
                wait_results_drained();
                n = $urandom_range(0, 5);
                write_reg(REG_MODE, COUNT_W'(MODE_LENGTH));
                write_reg(REG_LENGTH, COUNT_W'(n));
                repeat (n) send_byte(8'($urandom));
            end
            END_NO_DIGIT: begin
                send_text(";x");
                send_byte(CHAR_CR);
            end
            END_SIZE_OVERFLOW: begin
                send_text("10000000000000000");
                send_byte(CHAR_CR);
            end
            END_SIZE_TOO_LONG: begin
                send_text("1;");
                repeat (SIZE_LINE_LIMIT - 2) send_byte(8'($urandom_range(8'h20, 8'h7E)));
            end
            END_BAD_SIZE_LF: begin
                send_text("4");
                send_byte(CHAR_CR);
                send_text("x");
            end
            END_BAD_DATA_CR: begin
                send_text("2");
                send_crlf();
                send_text("abx");
            end
            END_BAD_DATA_LF: begin
                send_text("2");
                send_crlf();
                send_text("ab");
                send_byte(CHAR_CR);
                send_text("x");
            end
            END_CHUNKED_TOO_BIG: begin
                wait_results_drained();
                if ($urandom_range(0, 1) != 0) limit = '0;
                else limit = 40'(body_count) + 40'($urandom_range(0, 30));
                write_reg(REG_MAX, limit);
                limit_writes++;
                send_text("FFFFFFFFFFFFFFFF");
                send_crlf();
                repeat (16) send_byte(8'($urandom));
            end
            default: begin
                wait_results_drained();
                limit = 40'($urandom_range(0, 100));
                write_reg(REG_MODE, COUNT_W'(MODE_LENGTH));
                write_reg(REG_MAX, limit);
                write_reg(REG_LENGTH, limit + 1'b1);
                limit_writes++;
            end
        endcase
        repeat (12) send_byte(8'($urandom));
    endtask

    initial begin : run_tests
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_chunks();
        test_length_extremes();
        test_mode_switch_mid_chunk();
        test_count_at_limit();
        test_output_hold_off();
        test_input_pause();
        test_random_chunks();
        test_body_end();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d byte transfers, %0d payload bytes, %0d length mode detours",
                 bytes_sent, payload_seen, detour_count);
        $display("%0d limit rewrites, body ended by %s with status %0d",
                 limit_writes, body_ending.name(), body_st);
        if (error_count == 0 && decoded_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
